>>> hw/rtl/aac_pkg.sv
`default_nettype none

package aac_pkg;

   localparam int SEGMENTS_DEFAULT  = 4;
   localparam int SIG_DEPTH_DEFAULT = 256;

   localparam int EVAL_W   = 32;
   localparam int RAND_W   = 16;
   localparam int TEMP_W   = 16;
   localparam int STEPS_W  = 20;
   localparam int SCALE_W  = 23;
   localparam int STALL_W  = 10;
   localparam int REJ_W    = 5;
   localparam int SEGIDX_W = 3;
   localparam int TACC_W   = 31;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 20;
   localparam int NUM_W    = 48;
   localparam int DEN_W    = 32;
   localparam int SIG_W    = 17;

   localparam logic [STALL_W-1:0] STALL_LIMIT  = 10'd1000;
   localparam logic [REJ_W-1:0]   REJECT_LIMIT = 5'd20;
   localparam logic [REJ_W-1:0]   REJECT_SAT   = 5'd31;
   localparam logic [SCALE_W-1:0] SCALE_START  = 23'd4194304;
   localparam logic [SCALE_W-1:0] SCALE_GATE   = 23'd167;
   localparam logic [SCALE_W-1:0] SCALE_MIN    = 23'd16;
   localparam logic [SIG_W-1:0]   SIG_ONE      = 17'd65536;
   localparam logic [31:0]        RECIP_FIVE   = 32'hCCCC_CCCD;

   localparam longint unsigned Q30_ONE = 64'd1073741824;

   localparam logic [CSR_IDX_W-1:0] REG_SEG0_TEMP  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_SEG1_TEMP  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_SEG2_TEMP  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_SEG3_TEMP  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_SEG0_STEPS = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_SEG1_STEPS = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_SEG2_STEPS = 3'd6;
   localparam logic [CSR_IDX_W-1:0] REG_SEG3_STEPS = 3'd7;

   typedef enum logic [8:0] {
      S_IDLE   = 9'b000000001,
      S_REL    = 9'b000000010,
      S_TQ     = 9'b000000100,
      S_IDX    = 9'b000001000,
      S_ROM    = 9'b000010000,
      S_DECIDE = 9'b000100000,
      S_ADV    = 9'b001000000,
      S_SLOPE  = 9'b010000000,
      S_OUT    = 9'b100000000
   } state_type;

   typedef struct packed {
      logic             start;
      logic [NUM_W-1:0] num;
      logic [DEN_W-1:0] den;
   } div_req_type;

   typedef struct packed {
      logic             done;
      logic [NUM_W-1:0] quo;
   } div_rsp_type;

   function automatic longint unsigned div_small(longint unsigned v, int k);
      longint unsigned r;
      case (k)
         1:  r = v;
         2:  r = v / 2;
         3:  r = v / 3;
         4:  r = v / 4;
         5:  r = v / 5;
         6:  r = v / 6;
         7:  r = v / 7;
         8:  r = v / 8;
         9:  r = v / 9;
         10: r = v / 10;
         11: r = v / 11;
         12: r = v / 12;
         13: r = v / 13;
         14: r = v / 14;
         15: r = v / 15;
         16: r = v / 16;
         17: r = v / 17;
         18: r = v / 18;
         19: r = v / 19;
         20: r = v / 20;
         default: r = v;
      endcase
      return r;
   endfunction

   function automatic longint unsigned exp_neg_frac(longint unsigned y);
      longint unsigned term;
      longint unsigned pos;
      longint unsigned neg;
      term = Q30_ONE;
      pos  = Q30_ONE;
      neg  = 64'd0;
      for (int k = 1; k <= 20; k++) begin
         term = div_small((term * y) >> 30, k);
         if ((k % 2) == 1) begin
            neg = neg + term;
         end else begin
            pos = pos + term;
         end
      end
      return pos - neg;
   endfunction

   function automatic longint unsigned exp_neg(longint unsigned x);
      longint unsigned n;
      longint unsigned r;
      longint unsigned e1;
      n  = x >> 30;
      r  = exp_neg_frac(x & (Q30_ONE - 64'd1));
      e1 = exp_neg_frac(Q30_ONE);
      for (longint unsigned i = 0; i < n; i++) begin
         r = (r * e1) >> 30;
      end
      return r;
   endfunction

endpackage

`default_nettype wire

>>> hw/rtl/aac_div.sv
`default_nettype none

module aac_div (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire aac_pkg::div_req_type req,
   output aac_pkg::div_rsp_type      rsp
);

   localparam int CNT_W = $clog2(aac_pkg::NUM_W);

   logic                       busy_ff, busy_in;
   logic                       done_ff, done_in;
   logic [CNT_W-1:0]           cnt_ff, cnt_in;
   logic [aac_pkg::DEN_W-1:0]  rem_ff, rem_in;
   logic [aac_pkg::DEN_W-1:0]  den_ff, den_in;
   logic [aac_pkg::NUM_W-1:0]  quo_ff, quo_in;
   logic [aac_pkg::DEN_W:0]    shifted;
   logic [aac_pkg::DEN_W:0]    diff;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      quo_in  = quo_ff;
      shifted = {rem_ff, quo_ff[aac_pkg::NUM_W-1]};
      diff    = shifted - {1'b0, den_ff};
      if (req.start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(aac_pkg::NUM_W - 1);
         rem_in  = '0;
         den_in  = req.den;
         quo_in  = req.num;
      end else if (busy_ff) begin
         if (!diff[aac_pkg::DEN_W]) begin
            rem_in = diff[aac_pkg::DEN_W-1:0];
            quo_in = {quo_ff[aac_pkg::NUM_W-2:0], 1'b1};
         end else begin
            rem_in = shifted[aac_pkg::DEN_W-1:0];
            quo_in = {quo_ff[aac_pkg::NUM_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
      quo_ff <= quo_in;
   end

   assign rsp.done = done_ff;
   assign rsp.quo  = quo_ff;

endmodule

`default_nettype wire

>>> hw/rtl/annealing_acceptance_controller.sv
// An idle beat, or an initial beat with an empty schedule, goes straight to the output state;
// a trial's duration is set by up to three passes through the shared 48-step divider
// (relative change, sigmoid index, and the slope when a new segment is loaded).
// Throughput: one beat at a time; the next input beat is taken once the result is registered.
// Reset: synchronous, active high; clears the schedule registers and the annealing state.
`default_nettype none

module annealing_acceptance_controller #(
   parameter int SEGMENTS            = aac_pkg::SEGMENTS_DEFAULT,
   parameter int SIGMOID_TABLE_DEPTH = aac_pkg::SIG_DEPTH_DEFAULT
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_stall,
   input  wire logic                                req_is_initial,
   input  wire logic signed [aac_pkg::EVAL_W-1:0]   req_new_eval,
   input  wire logic [aac_pkg::RAND_W-1:0]          req_random_fraction,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_stall,
   output logic                                     rsp_accepted,
   output logic                                     rsp_new_best,
   output logic                                     rsp_restore_best,
   output logic                                     rsp_undo_change,
   output logic                                     rsp_schedule_done,
   output logic signed [aac_pkg::EVAL_W-1:0]        rsp_best_cost,
   output logic [aac_pkg::SCALE_W-1:0]              rsp_change_scale,
   output logic [aac_pkg::TEMP_W-1:0]               rsp_temperature,
   input  wire logic                                csr_valid,
   output logic                                     csr_ready,
   input  wire logic [aac_pkg::CSR_IDX_W-1:0]       csr_index,
   input  wire logic [aac_pkg::CSR_DATA_W-1:0]      csr_data
);

   localparam int IDX_W = $clog2(SIGMOID_TABLE_DEPTH);
   localparam int EW    = aac_pkg::EVAL_W;
   localparam int NW    = aac_pkg::NUM_W;
   localparam int DW    = aac_pkg::DEN_W;

   logic [aac_pkg::SIG_W-1:0] sig_rom [SIGMOID_TABLE_DEPTH];

   for (genvar g = 0; g < SIGMOID_TABLE_DEPTH; g++) begin : g_sig
      localparam longint unsigned X = longint'(g) * (64'd16 << 30) / SIGMOID_TABLE_DEPTH;
      localparam longint unsigned Den = aac_pkg::Q30_ONE + aac_pkg::exp_neg(X);
      localparam longint unsigned Entry = ((64'd1 << 46) + Den / 2) / Den;
      assign sig_rom[g] = aac_pkg::SIG_W'(Entry);
   end

   aac_pkg::state_type state_ff, state_in;

   logic [aac_pkg::TEMP_W-1:0]  seg_temp_ff  [4];
   logic [aac_pkg::STEPS_W-1:0] seg_steps_ff [4];

   logic signed [EW-1:0]          best_ff, best_in;
   logic signed [EW-1:0]          cur_ff, cur_in;
   logic signed [EW-1:0]          ev_ff, ev_in;
   logic [aac_pkg::STALL_W-1:0]   stall_ff, stall_in;
   logic [aac_pkg::REJ_W-1:0]     rej_ff, rej_in;
   logic [aac_pkg::SCALE_W-1:0]   scale_ff, scale_in;
   logic [aac_pkg::SEGIDX_W-1:0]  segidx_ff, segidx_in;
   logic [aac_pkg::STEPS_W-1:0]   step_ff, step_in;
   logic [aac_pkg::TACC_W-1:0]    tacc_ff, tacc_in;
   logic signed [31:0]            slope_ff, slope_in;
   logic                          running_ff, running_in;
   logic [aac_pkg::RAND_W-1:0]    rnd_ff, rnd_in;
   logic [aac_pkg::TEMP_W-1:0]    temp_ff, temp_in;
   logic signed [15:0]            tq_ff, tq_in;
   logic                          tq_ok_ff, tq_ok_in;
   logic                          neg_ff, neg_in;
   logic                          big_ff, big_in;
   logic                          k_ff, k_in;
   logic [aac_pkg::SIG_W-1:0]     rom_q_ff, rom_q_in;
   logic                          f_acc_ff, f_acc_in;
   logic                          f_nb_ff, f_nb_in;
   logic                          f_rb_ff, f_rb_in;
   logic                          f_undo_ff, f_undo_in;
   logic                          f_done_ff, f_done_in;
   logic                          div_start_ff, div_start_in;
   logic [NW-1:0]                 div_num_ff, div_num_in;
   logic [DW-1:0]                 div_den_ff, div_den_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic                          o_acc_ff, o_nb_ff, o_rb_ff, o_undo_ff, o_done_ff;
   logic signed [EW-1:0]          o_best_ff;
   logic [aac_pkg::SCALE_W-1:0]   o_scale_ff;
   logic [aac_pkg::TEMP_W-1:0]    o_temp_ff;
   logic                          out_load;

   aac_pkg::div_req_type div_req;
   aac_pkg::div_rsp_type div_rsp;

   // Segment loader operands.
   logic [1:0]                    ld_idx;
   logic [2:0]                    ld_nxt;
   logic [aac_pkg::TEMP_W-1:0]    ld_t0, ld_t1;
   logic [aac_pkg::STEPS_W-1:0]   ld_n;

   logic signed [EW:0]            rel_diff;
   logic [EW:0]                   rel_mag;
   logic [EW-1:0]                 cur_mag;
   logic [15:0]                   tq_mag;
   logic [aac_pkg::SIG_W-1:0]     sig_val;
   logic [aac_pkg::REJ_W-1:0]     rej_new;
   logic [24:0]                   scale_x4;
   logic [56:0]                   scale_prod;
   logic [aac_pkg::SCALE_W-1:0]   scale_shr;
   logic signed [32:0]            tacc_sum;
   logic [aac_pkg::STEPS_W-1:0]   step_next;
   logic [aac_pkg::SEGIDX_W-1:0]  seg_next;
   logic                          accept;

   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != aac_pkg::S_IDLE);
   assign csr_ready = 1'b1;

   assign div_req.start = div_start_ff;
   assign div_req.num   = div_num_ff;
   assign div_req.den   = div_den_ff;

   aac_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   always_comb begin
      step_next = step_ff + aac_pkg::STEPS_W'(1);
      seg_next  = segidx_ff + aac_pkg::SEGIDX_W'(1);
      ld_idx    = (state_ff == aac_pkg::S_IDLE) ? 2'd0 : seg_next[1:0];
      ld_nxt    = {1'b0, ld_idx} + 3'd1;
      ld_t0     = seg_temp_ff[ld_idx];
      ld_n      = seg_steps_ff[ld_idx];
      ld_t1     = '0;
      if ((int'(ld_nxt) < SEGMENTS) && (seg_steps_ff[ld_nxt[1:0]] != '0)) begin
         ld_t1 = seg_temp_ff[ld_nxt[1:0]];
      end
      rel_diff   = 33'(cur_ff) - 33'(ev_ff);
      rel_mag    = rel_diff[EW] ? 33'(-rel_diff) : 33'(rel_diff);
      cur_mag    = cur_ff[EW-1] ? 32'(-cur_ff) : 32'(cur_ff);
      tq_mag     = tq_ff[15] ? 16'(-tq_ff) : 16'(tq_ff);
      sig_val    = big_ff ? aac_pkg::SIG_ONE : rom_q_ff;
      if (tq_ff[15]) begin
         sig_val = aac_pkg::SIG_ONE - sig_val;
      end
      rej_new    = k_ff ? '0 :
                   ((rej_ff < aac_pkg::REJECT_SAT) ? rej_ff + aac_pkg::REJ_W'(1) : rej_ff);
      scale_x4   = {scale_ff, 2'b00};
      scale_prod = 57'(scale_x4) * 57'(aac_pkg::RECIP_FIVE);
      scale_shr  = scale_prod[34 +: aac_pkg::SCALE_W];
      tacc_sum   = 33'($signed({2'b00, tacc_tfix(tacc_ff)})) + 33'(slope_ff);
   end

   function automatic logic [aac_pkg::TACC_W-1:0] tacc_tfix(
         input logic [aac_pkg::TACC_W-1:0] v);
      return v;
   endfunction

   always_comb begin
      state_in     = state_ff;
      best_in      = best_ff;
      cur_in       = cur_ff;
      ev_in        = ev_ff;
      stall_in     = stall_ff;
      rej_in       = rej_ff;
      scale_in     = scale_ff;
      segidx_in    = segidx_ff;
      step_in      = step_ff;
      tacc_in      = tacc_ff;
      slope_in     = slope_ff;
      running_in   = running_ff;
      rnd_in       = rnd_ff;
      temp_in      = temp_ff;
      tq_in        = tq_ff;
      tq_ok_in     = tq_ok_ff;
      neg_in       = neg_ff;
      big_in       = big_ff;
      k_in         = k_ff;
      rom_q_in     = sig_rom[div_rsp.quo[IDX_W-1:0]];
      f_acc_in     = f_acc_ff;
      f_nb_in      = f_nb_ff;
      f_rb_in      = f_rb_ff;
      f_undo_in    = f_undo_ff;
      f_done_in    = f_done_ff;
      div_start_in = 1'b0;
      div_num_in   = div_num_ff;
      div_den_in   = div_den_ff;
      out_load     = 1'b0;

      case (state_ff)
         aac_pkg::S_IDLE: begin
            if (accept) begin
               ev_in     = req_new_eval;
               rnd_in    = req_random_fraction;
               temp_in   = '0;
               f_acc_in  = 1'b0;
               f_nb_in   = 1'b0;
               f_rb_in   = 1'b0;
               f_undo_in = 1'b0;
               f_done_in = 1'b0;
               state_in  = aac_pkg::S_OUT;
               if (req_is_initial) begin
                  best_in   = req_new_eval;
                  cur_in    = req_new_eval;
                  stall_in  = aac_pkg::STALL_LIMIT;
                  rej_in    = '0;
                  scale_in  = aac_pkg::SCALE_START;
                  segidx_in = '0;
                  f_nb_in   = 1'b1;
                  step_in   = '0;
                  if (seg_steps_ff[0] != '0) begin
                     running_in = 1'b1;
                     tacc_in    = {ld_t0, 15'd0};
                     if (ld_n > aac_pkg::STEPS_W'(1)) begin
                        neg_in       = (ld_t1 < ld_t0);
                        div_num_in   = NW'((ld_t1 < ld_t0) ? ld_t0 - ld_t1 : ld_t1 - ld_t0)
                                       << 15;
                        div_den_in   = DW'(ld_n - aac_pkg::STEPS_W'(1));
                        div_start_in = 1'b1;
                        state_in     = aac_pkg::S_SLOPE;
                     end else begin
                        slope_in = '0;
                     end
                  end else begin
                     running_in = 1'b0;
                     tacc_in    = '0;
                     slope_in   = '0;
                     f_rb_in    = 1'b1;
                     f_done_in  = 1'b1;
                  end
               end else if (running_ff) begin
                  temp_in = tacc_ff[aac_pkg::TACC_W-1:15];
                  if (req_new_eval < best_ff) begin
                     best_in  = req_new_eval;
                     f_nb_in  = 1'b1;
                     stall_in = aac_pkg::STALL_LIMIT;
                     state_in = aac_pkg::S_REL;
                  end else if (stall_ff == '0) begin
                     cur_in   = best_ff;
                     f_rb_in  = 1'b1;
                     stall_in = aac_pkg::STALL_LIMIT;
                     state_in = aac_pkg::S_ADV;
                  end else begin
                     stall_in = stall_ff - aac_pkg::STALL_W'(1);
                     state_in = aac_pkg::S_REL;
                  end
               end
            end
         end

         aac_pkg::S_REL: begin
            // The first cycle launches the divide, or settles a zero current cost.
            if (!neg_ff && !tq_ok_ff) begin
               tq_ok_in = 1'b1;
               if (cur_ff == '0) begin
                  neg_in = 1'b0;
                  if (ev_ff < 0) begin
                     tq_in = 16'sd32767;
                  end else if (ev_ff > 0) begin
                     tq_in = -16'sd32768;
                  end else begin
                     tq_ok_in = 1'b0;
                  end
                  state_in = aac_pkg::S_TQ;
               end else begin
                  neg_in       = rel_diff[EW] ^ cur_ff[EW-1];
                  div_num_in   = NW'(rel_mag) << 14;
                  div_den_in   = cur_mag;
                  div_start_in = 1'b1;
                  tq_ok_in     = 1'b1;
                  state_in     = aac_pkg::S_IDX;
               end
            end
         end

         aac_pkg::S_TQ: begin
            if (!tq_ok_ff) begin
               k_in     = 1'b0;
               state_in = aac_pkg::S_DECIDE;
            end else if (temp_ff != '0) begin
               div_num_in   = NW'(tq_mag) * NW'(SIGMOID_TABLE_DEPTH);
               div_den_in   = DW'({temp_ff, 6'd0});
               div_start_in = 1'b1;
               state_in     = aac_pkg::S_ROM;
            end else begin
               k_in     = (tq_ff > 0);
               state_in = aac_pkg::S_DECIDE;
            end
         end

         aac_pkg::S_IDX: begin
            if (div_rsp.done) begin
               if (neg_ff) begin
                  tq_in = (div_rsp.quo > NW'(32768)) ? -16'sd32768 : 16'(-div_rsp.quo[15:0]);
               end else begin
                  tq_in = (div_rsp.quo > NW'(32767)) ? 16'sd32767 : $signed(div_rsp.quo[15:0]);
               end
               neg_in   = 1'b0;
               state_in = aac_pkg::S_TQ;
            end
         end

         aac_pkg::S_ROM: begin
            if (div_rsp.done) begin
               big_in = (div_rsp.quo >= NW'(SIGMOID_TABLE_DEPTH));
               k_in   = 1'b0;
            end
            if (div_start_ff == 1'b0 && !div_rsp.done && tq_ok_ff == 1'b0) begin
               k_in     = (sig_val >= aac_pkg::SIG_W'(rnd_ff));
               state_in = aac_pkg::S_DECIDE;
            end
            if (div_rsp.done) begin
               tq_ok_in = 1'b0;
            end
         end

         aac_pkg::S_DECIDE: begin
            tq_ok_in = 1'b0;
            neg_in   = 1'b0;
            if (k_ff) begin
               cur_in   = ev_ff;
               f_acc_in = 1'b1;
            end else begin
               f_undo_in = 1'b1;
            end
            rej_in = rej_new;
            if ((rej_new > aac_pkg::REJECT_LIMIT) && (scale_ff > aac_pkg::SCALE_GATE)) begin
               rej_in   = '0;
               scale_in = (scale_shr < aac_pkg::SCALE_MIN) ? aac_pkg::SCALE_MIN : scale_shr;
            end
            state_in = aac_pkg::S_ADV;
         end

         aac_pkg::S_ADV: begin
            tq_ok_in = 1'b0;
            neg_in   = 1'b0;
            step_in  = step_next;
            if (tacc_sum < 0) begin
               tacc_in = '0;
            end else if (tacc_sum[32:31] != 2'b00) begin
               tacc_in = '1;
            end else begin
               tacc_in = tacc_sum[aac_pkg::TACC_W-1:0];
            end
            state_in = aac_pkg::S_OUT;
            if (step_next >= seg_steps_ff[segidx_ff[1:0]]) begin
               segidx_in = seg_next;
               if ((int'(seg_next) >= SEGMENTS) || (seg_steps_ff[seg_next[1:0]] == '0)) begin
                  running_in = 1'b0;
                  f_done_in  = 1'b1;
                  f_rb_in    = 1'b1;
                  cur_in     = best_ff;
               end else begin
                  tacc_in = {ld_t0, 15'd0};
                  step_in = '0;
                  if (ld_n > aac_pkg::STEPS_W'(1)) begin
                     neg_in       = (ld_t1 < ld_t0);
                     div_num_in   = NW'((ld_t1 < ld_t0) ? ld_t0 - ld_t1 : ld_t1 - ld_t0) << 15;
                     div_den_in   = DW'(ld_n - aac_pkg::STEPS_W'(1));
                     div_start_in = 1'b1;
                     state_in     = aac_pkg::S_SLOPE;
                  end else begin
                     slope_in = '0;
                  end
               end
            end
         end

         aac_pkg::S_SLOPE: begin
            if (div_rsp.done) begin
               slope_in = neg_ff ? -$signed(div_rsp.quo[31:0]) : $signed(div_rsp.quo[31:0]);
               neg_in   = 1'b0;
               state_in = aac_pkg::S_OUT;
            end
         end

         aac_pkg::S_OUT: begin
            tq_ok_in = 1'b0;
            neg_in   = 1'b0;
            if (!rsp_valid_ff || !rsp_stall) begin
               out_load = 1'b1;
               state_in = aac_pkg::S_IDLE;
            end
         end

         default: begin
            state_in = aac_pkg::S_IDLE;
         end
      endcase

      rsp_valid_in = out_load ? 1'b1 : (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= aac_pkg::S_IDLE;
         best_ff      <= '0;
         cur_ff       <= '0;
         stall_ff     <= aac_pkg::STALL_LIMIT;
         rej_ff       <= '0;
         scale_ff     <= aac_pkg::SCALE_START;
         segidx_ff    <= '0;
         step_ff      <= '0;
         tacc_ff      <= '0;
         slope_ff     <= '0;
         running_ff   <= 1'b0;
         tq_ok_ff     <= 1'b0;
         neg_ff       <= 1'b0;
         div_start_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < 4; i++) begin
            seg_temp_ff[i]  <= '0;
            seg_steps_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         best_ff      <= best_in;
         cur_ff       <= cur_in;
         stall_ff     <= stall_in;
         rej_ff       <= rej_in;
         scale_ff     <= scale_in;
         segidx_ff    <= segidx_in;
         step_ff      <= step_in;
         tacc_ff      <= tacc_in;
         slope_ff     <= slope_in;
         running_ff   <= running_in;
         tq_ok_ff     <= tq_ok_in;
         neg_ff       <= neg_in;
         div_start_ff <= div_start_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            case (csr_index)
               aac_pkg::REG_SEG0_TEMP:  seg_temp_ff[0]  <= csr_data[aac_pkg::TEMP_W-1:0];
               aac_pkg::REG_SEG1_TEMP:  seg_temp_ff[1]  <= csr_data[aac_pkg::TEMP_W-1:0];
               aac_pkg::REG_SEG2_TEMP:  seg_temp_ff[2]  <= csr_data[aac_pkg::TEMP_W-1:0];
               aac_pkg::REG_SEG3_TEMP:  seg_temp_ff[3]  <= csr_data[aac_pkg::TEMP_W-1:0];
               aac_pkg::REG_SEG0_STEPS: seg_steps_ff[0] <= csr_data;
               aac_pkg::REG_SEG1_STEPS: seg_steps_ff[1] <= csr_data;
               aac_pkg::REG_SEG2_STEPS: seg_steps_ff[2] <= csr_data;
               aac_pkg::REG_SEG3_STEPS: seg_steps_ff[3] <= csr_data;
               default: ;
            endcase
         end
      end
      ev_ff      <= ev_in;
      rnd_ff     <= rnd_in;
      temp_ff    <= temp_in;
      tq_ff      <= tq_in;
      big_ff     <= big_in;
      k_ff       <= k_in;
      rom_q_ff   <= rom_q_in;
      f_acc_ff   <= f_acc_in;
      f_nb_ff    <= f_nb_in;
      f_rb_ff    <= f_rb_in;
      f_undo_ff  <= f_undo_in;
      f_done_ff  <= f_done_in;
      div_num_ff <= div_num_in;
      div_den_ff <= div_den_in;
      if (out_load) begin
         o_acc_ff   <= f_acc_ff;
         o_nb_ff    <= f_nb_ff;
         o_rb_ff    <= f_rb_ff;
         o_undo_ff  <= f_undo_ff;
         o_done_ff  <= f_done_ff;
         o_best_ff  <= best_ff;
         o_scale_ff <= scale_ff;
         o_temp_ff  <= temp_ff;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_accepted      = o_acc_ff;
   assign rsp_new_best      = o_nb_ff;
   assign rsp_restore_best  = o_rb_ff;
   assign rsp_undo_change   = o_undo_ff;
   assign rsp_schedule_done = o_done_ff;
   assign rsp_best_cost     = o_best_ff;
   assign rsp_change_scale  = o_scale_ff;
   assign rsp_temperature   = o_temp_ff;

endmodule

`default_nettype wire

>>> tb/tb_annealing_acceptance_controller.sv
`timescale 1ns/1ps
`default_nettype none

module tb_annealing_acceptance_controller;
   timeunit 1ns;
   timeprecision 1ps;

   import aac_pkg::*;

   typedef struct {
      bit               accepted;
      bit               new_best;
      bit               restore_best;
      bit               undo_change;
      bit               schedule_done;
      logic signed [31:0] best_cost;
      logic [22:0]      change_scale;
      logic [15:0]      temperature;
   } decision_t;

   class annealer_scoreboard;
      int unsigned      seg_temp[4];
      int unsigned      seg_steps[4];
      longint           best_cost;
      longint           current_cost;
      int unsigned      stall_left;
      int unsigned      reject_count;
      int unsigned      scale;
      int unsigned      seg_idx;
      int unsigned      seg_step;
      longint           temp_acc;
      longint           temp_slope;
      bit               active;
      int unsigned      sig_lut[256];
      decision_t        pending[$];
      int               mismatches;

      function longint unsigned exp_fraction(longint unsigned y);
         longint unsigned term;
         longint unsigned pos;
         longint unsigned neg;
         term = 64'd1 << 30;
         pos  = term;
         neg  = 0;
         for (int k = 1; k <= 20; k++) begin
            term = ((term * y) >> 30) / k;
            if (k % 2 == 1) neg += term;
            else pos += term;
         end
         return pos - neg;
      endfunction

      function void reset_state();
         longint unsigned x;
         longint unsigned r;
         longint unsigned e1;
         longint unsigned den;
         for (int i = 0; i < 4; i++) begin
            seg_temp[i]  = 0;
            seg_steps[i] = 0;
         end
         best_cost    = 0;
         current_cost = 0;
         stall_left   = 1000;
         reject_count = 0;
         scale        = 4194304;
         seg_idx      = 0;
         seg_step     = 0;
         temp_acc     = 0;
         temp_slope   = 0;
         active       = 0;
         mismatches   = 0;
         e1 = exp_fraction(64'd1 << 30);
         for (int i = 0; i < 256; i++) begin
            x = longint'(i) << 26;
            r = exp_fraction(x & ((64'd1 << 30) - 1));
            for (longint unsigned n = 0; n < (x >> 30); n++) r = (r * e1) >> 30;
            den = (64'd1 << 30) + r;
            sig_lut[i] = ((64'd1 << 46) + den / 2) / den;
         end
      endfunction

      function void write_reg(int unsigned idx, int unsigned data);
         if (idx < 4) seg_temp[idx] = data & 16'hFFFF;
         else seg_steps[idx - 4] = data & 20'hFFFFF;
      endfunction

      function void start_segment(int unsigned i);
         longint t0;
         longint t1;
         t0 = seg_temp[i];
         t1 = 0;
         if (i + 1 < 4 && seg_steps[i + 1] != 0) t1 = seg_temp[i + 1];
         temp_acc   = t0 * 32768;
         temp_slope = (seg_steps[i] > 1) ? ((t1 - t0) * 32768) / longint'(seg_steps[i] - 1) : 0;
         seg_step   = 0;
      endfunction

      function int unsigned sigmoid(longint t, longint unsigned temp);
         longint unsigned mag;
         longint unsigned idx;
         int unsigned s;
         mag = (t < 0) ? -t : t;
         idx = mag * 256 / (64 * temp);
         s = (idx >= 256) ? 65536 : sig_lut[idx];
         return (t < 0) ? 65536 - s : s;
      endfunction

      function void note_beat(bit is_initial, logic signed [31:0] eval_in, logic [15:0] rnd);
         decision_t d;
         longint ev;
         longint q;
         longint a;
         longint unsigned temp;
         bit skip;
         bit keep;
         bit ok;
         d  = '{default: 0};
         ev = eval_in;
         temp = 0;
         if (is_initial) begin
            best_cost    = ev;
            current_cost = ev;
            stall_left   = 1000;
            reject_count = 0;
            scale        = 4194304;
            seg_idx      = 0;
            d.new_best   = 1;
            active       = seg_steps[0] != 0;
            if (active) begin
               start_segment(0);
            end else begin
               temp_acc   = 0;
               temp_slope = 0;
               seg_step   = 0;
               d.restore_best  = 1;
               d.schedule_done = 1;
            end
         end else if (active) begin
            skip = 0;
            temp = temp_acc >> 15;
            if (ev < best_cost) begin
               best_cost  = ev;
               d.new_best = 1;
               stall_left = 1000;
            end else if (stall_left == 0) begin
               current_cost   = best_cost;
               d.restore_best = 1;
               stall_left     = 1000;
               skip           = 1;
            end else begin
               stall_left--;
            end
            if (!skip) begin
               ok = 1;
               q  = 0;
               if (current_cost != 0) begin
                  q = ((current_cost - ev) * 16384) / current_cost;
                  if (q > 32767) q = 32767;
                  if (q < -32768) q = -32768;
               end else if (ev < 0) begin
                  q = 32767;
               end else if (ev > 0) begin
                  q = -32768;
               end else begin
                  ok = 0;
               end
               if (!ok) keep = 0;
               else if (temp != 0) keep = sigmoid(q, temp) >= rnd;
               else keep = q > 0;
               if (keep) begin
                  current_cost = ev;
                  reject_count = 0;
                  d.accepted   = 1;
               end else begin
                  d.undo_change = 1;
                  if (reject_count < 31) reject_count++;
               end
               if (reject_count > 20 && scale > 167) begin
                  reject_count = 0;
                  scale = (longint'(scale) * 4) / 5;
                  if (scale < 16) scale = 16;
               end
            end
            seg_step++;
            a = temp_acc + temp_slope;
            if (a < 0) a = 0;
            if (a > 64'h7FFF_FFFF) a = 64'h7FFF_FFFF;
            temp_acc = a;
            if (seg_step >= seg_steps[seg_idx]) begin
               seg_idx++;
               if (seg_idx >= 4 || seg_steps[seg_idx] == 0) begin
                  active          = 0;
                  d.schedule_done = 1;
                  d.restore_best  = 1;
                  current_cost    = best_cost;
               end else begin
                  start_segment(seg_idx);
               end
            end
         end
         d.best_cost    = best_cost[31:0];
         d.change_scale = scale[22:0];
         d.temperature  = temp[15:0];
         pending.push_back(d);
      endfunction

      task report(string what, longint got, longint want);
         $display("%0t: %s got %0d expected %0d", $realtime, what, got, want);
         mismatches++;
      endtask

      task check_beat(decision_t got);
         decision_t want;
         if (pending.size() == 0) begin
            $display("%0t: result beat with no decision outstanding", $realtime);
            mismatches++;
         end else begin
            want = pending.pop_front();
            if (got.accepted != want.accepted) report("accepted", got.accepted, want.accepted);
            if (got.new_best != want.new_best) report("new_best", got.new_best, want.new_best);
            if (got.restore_best != want.restore_best)
               report("restore_best", got.restore_best, want.restore_best);
            if (got.undo_change != want.undo_change)
               report("undo_change", got.undo_change, want.undo_change);
            if (got.schedule_done != want.schedule_done)
               report("schedule_done", got.schedule_done, want.schedule_done);
            if (got.best_cost !== want.best_cost)
               report("best_cost", got.best_cost, want.best_cost);
            if (got.change_scale !== want.change_scale)
               report("change_scale", got.change_scale, want.change_scale);
            if (got.temperature !== want.temperature)
               report("temperature", got.temperature, want.temperature);
         end
      endtask
   endclass

   logic                     clock = 0;
   logic                     reset = 1;
   logic                     req_valid = 0;
   logic                     req_stall;
   logic                     req_is_initial = 0;
   logic signed [EVAL_W-1:0] req_new_eval = '0;
   logic [RAND_W-1:0]        req_random_fraction = '0;
   logic                     rsp_valid;
   logic                     rsp_stall = 0;
   logic                     rsp_accepted;
   logic                     rsp_new_best;
   logic                     rsp_restore_best;
   logic                     rsp_undo_change;
   logic                     rsp_schedule_done;
   logic signed [EVAL_W-1:0] rsp_best_cost;
   logic [SCALE_W-1:0]       rsp_change_scale;
   logic [TEMP_W-1:0]        rsp_temperature;
   logic                     csr_valid = 0;
   logic                     csr_ready;
   logic [CSR_IDX_W-1:0]     csr_index = '0;
   logic [CSR_DATA_W-1:0]    csr_data = '0;

   annealer_scoreboard sb;
   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   logic signed [31:0] anchor;

   annealing_acceptance_controller u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_is_initial(req_is_initial),
      .req_new_eval(req_new_eval), .req_random_fraction(req_random_fraction),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_accepted(rsp_accepted),
      .rsp_new_best(rsp_new_best), .rsp_restore_best(rsp_restore_best),
      .rsp_undo_change(rsp_undo_change), .rsp_schedule_done(rsp_schedule_done),
      .rsp_best_cost(rsp_best_cost), .rsp_change_scale(rsp_change_scale),
      .rsp_temperature(rsp_temperature),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_index(csr_index),
      .csr_data(csr_data)
   );

   always #5 clock = ~clock;

   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(99) < recv_stall_pct);
   end

   always @(posedge clock) begin
      decision_t got;
      if (!reset && rsp_valid && !rsp_stall) begin
         got.accepted      = rsp_accepted;
         got.new_best      = rsp_new_best;
         got.restore_best  = rsp_restore_best;
         got.undo_change   = rsp_undo_change;
         got.schedule_done = rsp_schedule_done;
         got.best_cost     = rsp_best_cost;
         got.change_scale  = rsp_change_scale;
         got.temperature   = rsp_temperature;
         sb.check_beat(got);
      end
   end

   task automatic csr_write(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      csr_valid = 1;
      csr_index = idx;
      csr_data  = data;
      do @(posedge clock); while (!csr_ready);
      sb.write_reg(idx, data);
      @(negedge clock);
      csr_valid = 0;
   endtask

   task automatic load_schedule(int unsigned t0, int unsigned t1, int unsigned t2,
                                int unsigned t3, int unsigned n0, int unsigned n1,
                                int unsigned n2, int unsigned n3);
      csr_write(REG_SEG0_TEMP, t0);
      csr_write(REG_SEG1_TEMP, t1);
      csr_write(REG_SEG2_TEMP, t2);
      csr_write(REG_SEG3_TEMP, t3);
      csr_write(REG_SEG0_STEPS, n0);
      csr_write(REG_SEG1_STEPS, n1);
      csr_write(REG_SEG2_STEPS, n2);
      csr_write(REG_SEG3_STEPS, n3);
   endtask

   task automatic send_beat(bit is_initial, logic signed [31:0] ev, logic [15:0] rnd);
      while ($urandom_range(99) < send_idle_pct) @(negedge clock);
      req_valid           = 1;
      req_is_initial      = is_initial;
      req_new_eval        = ev;
      req_random_fraction = rnd;
      do @(posedge clock); while (req_stall);
      sb.note_beat(is_initial, ev, rnd);
      @(negedge clock);
      req_valid = 0;
   endtask

   task automatic drain();
      int guard;
      guard = 0;
      while (sb.pending.size() != 0 && guard < 200000) begin
         @(negedge clock);
         guard++;
      end
      repeat (20) @(negedge clock);
   endtask

   task automatic set_idling(int mode);
      case (mode % 4)
         0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
         1: begin send_idle_pct = 69; recv_stall_pct = 0;  end
         2: begin send_idle_pct = 0;  recv_stall_pct = 69; end
         default: begin send_idle_pct = 10; recv_stall_pct = 10; end
      endcase
   endtask

   function automatic logic signed [31:0] near_cost(logic signed [31:0] base);
      longint v;
      case ($urandom_range(9))
         0: v = $signed($urandom);
         1: v = base;
         2: v = 0;
         default: v = longint'(base) + $signed($urandom_range(4000)) - 2000;
      endcase
      if (v > 64'sh7FFF_FFFF) v = 64'sh7FFF_FFFF;
      if (v < -64'sh8000_0000) v = -64'sh8000_0000;
      return v[31:0];
   endfunction

   initial begin
      #30ms;
      $display("Mismatches found");
      $finish;
   end

   initial begin
      sb = new();
      sb.reset_state();
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 0;

      send_beat(0, 32'sd5, 16'hFFFF);
      send_beat(1, 32'sd1000, 16'd0);
      drain();

      load_schedule(16'hFFFF, 16'd0, 16'd4096, 16'd1, 20'd1, 20'd3, 20'd2, 20'd1);
      send_beat(1, 32'sh7FFF_FFFF, 16'd0);
      send_beat(0, -32'sh8000_0000, 16'hFFFF);
      send_beat(0, 32'sh7FFF_FFFF, 16'd0);
      send_beat(0, 32'sd0, 16'h8000);
      send_beat(0, 32'sd12, 16'h0001);
      send_beat(0, 32'sd12, 16'hFFFF);
      send_beat(0, 32'sd40, 16'd0);
      send_beat(0, 32'sd1, 16'd0);
      send_beat(1, 32'sd0, 16'h1234);
      send_beat(0, 32'sd7, 16'd0);
      send_beat(0, 32'sd0, 16'd0);
      send_beat(0, -32'sd3, 16'd0);
      send_beat(1, 32'sd0, 16'h0);
      send_beat(0, 32'sd0, 16'h0);
      drain();

      load_schedule(16'd100, 16'hFFFF, 16'd0, 16'd0, 20'd0, 20'hFFFFF, 20'd1, 20'd1);
      send_beat(1, 32'sd77, 16'd0);
      send_beat(0, 32'sd1, 16'd0);
      drain();

      // Long zero-temperature run: every trial is rejected, so the scale shrinks to its
      // gate and the stall counter expires.
      set_idling(2);
      load_schedule(16'd0, 16'd0, 16'hFFFF, 16'hFFFF, 20'hFFFFF, 20'd0, 20'd5, 20'd5);
      anchor = $signed($urandom_range(100000, 1000));
      send_beat(1, anchor, 16'd0);
      for (int i = 0; i < 1030; i++) begin
         if (i % 200 == 0) set_idling(i / 200);
         send_beat(0, anchor + $signed($urandom_range(5000)), $urandom);
      end
      drain();

      for (int ph = 0; ph < 8; ph++) begin
         int unsigned n[4];
         set_idling(ph);
         for (int s = 0; s < 4; s++) n[s] = ($urandom_range(5) == 0) ? 0 : $urandom_range(40, 1);
         if (ph == 7) n[0] = 20'hFFFFF;
         load_schedule($urandom_range(20'hFFFFF), (ph == 6) ? 0 : $urandom_range(16'hFFFF),
                       $urandom_range(16'hFFFF), $urandom_range(16'hFFFF),
                       n[0], n[1], n[2], n[3]);
         anchor = $signed($urandom);
         send_beat(1, anchor, $urandom);
         for (int i = 0; i < 40; i++) begin
            if ($urandom_range(19) == 0) begin
               anchor = $signed($urandom);
               send_beat(1, anchor, $urandom);
            end else begin
               send_beat(0, near_cost(anchor), $urandom);
            end
         end
         drain();
      end

      set_idling(0);
      drain();
      if (sb.mismatches == 0 && sb.pending.size() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

`default_nettype wire

>>> sim.f
hw/rtl/aac_pkg.sv
hw/rtl/aac_div.sv
hw/rtl/annealing_acceptance_controller.sv
tb/tb_annealing_acceptance_controller.sv
